/* rtl/core/ffsa_pkg.sv */
// Shared constants, codes and the segment record of the first-fit allocator.
package ffsa_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int OFS_W        = 24;
  localparam int PAGES_W      = 13;
  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int HEADER_BYTES = 32;
  localparam int ALIGN_BYTES  = 16;
  localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
  localparam int SPAN_PAGES   = (1 << OFS_W) / PAGE_BYTES;
  localparam logic [PAGES_W-1:0] RESET_MAX_PAGES = PAGES_W'(256);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_NO_MEM   = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic [OFS_W-1:0]  start;
    logic [OFS_W-1:0]  size;
    logic              free;
    logic [SEG_AW-1:0] nxt;
  } seg_t;

endpackage

/* rtl/core/first_fit_segment_allocator.sv */
// First-fit segment allocator: sequencer, segment table and result register.
// Zero-size and oversize requests are answered in the cycle after the beat; an
// allocate walks the chain one segment at a time (one table read port), then may
// grow the heap and split the segment; a free scans the table segment by segment.
// One item at a time; the next beat is taken once the result register is free.
// rst is synchronous: table entry 0 becomes one free first page, limit 256 pages.
module first_fit_segment_allocator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      req_type,
  input  logic [ffsa_pkg::OFS_W-1:0] request_size,
  input  logic [ffsa_pkg::OFS_W-1:0] block_offset,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ffsa_pkg::OFS_W-1:0] granted_offset,
  output logic [1:0]                status,
  input  logic                      cfg_wr_en,
  input  logic [ffsa_pkg::PAGES_W-1:0] cfg_wr_data
);
  import ffsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_GRD, S_GCHK, S_GRANT, S_WR, S_FRD, S_FCHK
  } state_t;

  state_t              state;
  seg_t                table_mem [MAX_SEGMENTS];
  seg_t                rd_data;
  seg_t                rec;
  logic [SEG_AW-1:0]   idx;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    seg_count;
  logic [SEG_AW-1:0]   last_seg;
  logic [PAGES_W-1:0]  heap_pages;
  logic [PAGES_W-1:0]  max_heap_pages;
  logic [OFS_W:0]      need;
  logic [OFS_W-1:0]    offset;

  logic                mem_we;
  logic [SEG_AW-1:0]   mem_waddr;
  seg_t                mem_wdata;
  logic [SEG_AW-1:0]   mem_raddr;

  logic [OFS_W:0]      need_next;
  logic [PAGES_W-1:0]  cap;
  logic [OFS_W:0]      grow_ext;
  logic [OFS_W:0]      new_ext;
  logic [PAGES_W-1:0]  pages_ext;
  logic [PAGES_W-1:0]  pages_new;
  logic [OFS_W:0]      rest;
  logic                do_split;
  logic [OFS_W:0]      rd_ofs;
  logic                fits;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);

  always_comb begin
    need_next = ((OFS_W+1)'(request_size) + (OFS_W+1)'(ALIGN_BYTES - 1))
                >> ALIGN_SHIFT << ALIGN_SHIFT;
    cap       = (max_heap_pages > PAGES_W'(SPAN_PAGES)) ? PAGES_W'(SPAN_PAGES)
                                                        : max_heap_pages;
    grow_ext  = need - (OFS_W+1)'(rd_data.size) + (OFS_W+1)'(PAGE_BYTES - 1);
    new_ext   = need + (OFS_W+1)'(HEADER_BYTES + PAGE_BYTES - 1);
    pages_ext = grow_ext[PAGE_SHIFT +: PAGES_W];
    pages_new = new_ext[PAGE_SHIFT +: PAGES_W];
    rest      = (OFS_W+1)'(rec.size) - need;
    do_split  = (rest >= (OFS_W+1)'(HEADER_BYTES)) &&
                (seg_count < CNT_W'(MAX_SEGMENTS));
    rd_ofs    = (OFS_W+1)'(rd_data.start) + (OFS_W+1)'(HEADER_BYTES);
    fits      = rd_data.free && ((OFS_W+1)'(rd_data.size) >= need);
  end

  // single write port, driven by the sequencer
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = rec;
    mem_raddr = idx;
    case (state)
      S_GRD:   mem_raddr = last_seg;
      S_FRD:   mem_raddr = cnt[SEG_AW-1:0];
      S_GCHK: begin
        // appending behind a busy last segment relinks it
        mem_waddr = last_seg;
        mem_wdata = rd_data;
        mem_wdata.nxt = seg_count[SEG_AW-1:0];
        mem_we = !rd_data.free && (seg_count < CNT_W'(MAX_SEGMENTS)) &&
                 ((PAGES_W+1)'(heap_pages) + (PAGES_W+1)'(pages_new) <= (PAGES_W+1)'(cap));
      end
      S_GRANT: begin
        mem_we    = do_split;
        mem_waddr = seg_count[SEG_AW-1:0];
        mem_wdata.start = rec.start + OFS_W'(HEADER_BYTES) + need[OFS_W-1:0];
        mem_wdata.size  = rest[OFS_W-1:0] - OFS_W'(HEADER_BYTES);
        mem_wdata.free  = 1'b1;
        mem_wdata.nxt   = rec.nxt;
      end
      S_WR: begin
        mem_we = 1'b1;
        mem_wdata.free = 1'b0;
      end
      S_FCHK: begin
        mem_we    = (rd_ofs == (OFS_W+1)'(offset));
        mem_waddr = cnt[SEG_AW-1:0];
        mem_wdata = rd_data;
        mem_wdata.free = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_mem[0] <= '{start: '0, size: OFS_W'(PAGE_BYTES - HEADER_BYTES),
                        free: 1'b1, nxt: '0};
    end else if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      seg_count      <= CNT_W'(1);
      last_seg       <= '0;
      heap_pages     <= PAGES_W'(1);
      max_heap_pages <= RESET_MAX_PAGES;
    end else begin
      if (cfg_wr_en) max_heap_pages <= cfg_wr_data;
      // a beat taken in the same cycle decides the flag itself
      if (out_valid && out_ready && !(in_valid && in_ready)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            out_valid <= (req_type == REQ_ALLOC) &&
                         (request_size == '0 || need_next[OFS_W]);
            need   <= need_next;
            offset <= block_offset;
            idx    <= '0;
            cnt    <= '0;
            if (req_type == REQ_FREE) begin
              state <= S_FRD;
            end else if (request_size == '0) begin
              status <= ST_ZERO; granted_offset <= '0;
            end else if (need_next[OFS_W]) begin
              status <= ST_NO_MEM; granted_offset <= '0;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (fits) begin
            rec   <= rd_data;
            state <= S_GRANT;
          end else if (idx == last_seg || cnt == CNT_W'(MAX_SEGMENTS - 1)) begin
            state <= S_GRD;
          end else begin
            idx   <= rd_data.nxt;
            cnt   <= cnt + CNT_W'(1);
            state <= S_RD;
          end
        end
        S_GRD: state <= S_GCHK;
        S_GCHK: begin
          if (rd_data.free) begin
            if ((PAGES_W+1)'(heap_pages) + (PAGES_W+1)'(pages_ext) > (PAGES_W+1)'(cap)) begin
              out_valid <= 1'b1; status <= ST_NO_MEM; granted_offset <= '0;
              state <= S_IDLE;
            end else begin
              rec        <= '{start: rd_data.start,
                              size: rd_data.size + (OFS_W'(pages_ext) << PAGE_SHIFT),
                              free: rd_data.free, nxt: rd_data.nxt};
              heap_pages <= heap_pages + pages_ext;
              idx        <= last_seg;
              state      <= S_GRANT;
            end
          end else if (seg_count >= CNT_W'(MAX_SEGMENTS) ||
                       (PAGES_W+1)'(heap_pages) + (PAGES_W+1)'(pages_new) > (PAGES_W+1)'(cap)) begin
            out_valid <= 1'b1; status <= ST_NO_MEM; granted_offset <= '0;
            state <= S_IDLE;
          end else begin
            rec.start  <= OFS_W'(heap_pages) << PAGE_SHIFT;
            rec.size   <= (OFS_W'(pages_new) << PAGE_SHIFT) - OFS_W'(HEADER_BYTES);
            rec.free   <= 1'b1;
            rec.nxt    <= '0;
            idx        <= seg_count[SEG_AW-1:0];
            last_seg   <= seg_count[SEG_AW-1:0];
            seg_count  <= seg_count + CNT_W'(1);
            heap_pages <= heap_pages + pages_new;
            state      <= S_GRANT;
          end
        end
        S_GRANT: begin
          if (do_split) begin
            rec.nxt   <= seg_count[SEG_AW-1:0];
            rec.size  <= need[OFS_W-1:0];
            if (idx == last_seg) last_seg <= seg_count[SEG_AW-1:0];
            seg_count <= seg_count + CNT_W'(1);
          end
          state <= S_WR;
        end
        S_WR: begin
          out_valid      <= 1'b1;
          status         <= ST_OK;
          granted_offset <= rec.start + OFS_W'(HEADER_BYTES);
          state          <= S_IDLE;
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (rd_ofs == (OFS_W+1)'(offset)) begin
            out_valid <= 1'b1; status <= ST_OK; granted_offset <= '0;
            state <= S_IDLE;
          end else if (cnt + CNT_W'(1) >= seg_count) begin
            out_valid <= 1'b1; status <= ST_IGNORED; granted_offset <= '0;
            state <= S_IDLE;
          end else begin
            cnt   <= cnt + CNT_W'(1);
            state <= S_FRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ffsa_checker.sv */
// Port-level checks for the first-fit allocator, bound to the top level.
module ffsa_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       req_type,
  input logic [ffsa_pkg::OFS_W-1:0] request_size,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ffsa_pkg::OFS_W-1:0] granted_offset,
  input logic [1:0]                 status
);
  import ffsa_pkg::*;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted_offset) && $stable(status))
    else $error("result beat changed while stalled");

  a_no_ofs_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_offset == '0)
    else $error("offset given with a failing status");

  // only an immediate answer may let the next beat in straight away
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready || out_valid)
    else $error("second beat taken while busy");

  a_zero_size: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_ALLOC && request_size == '0
    |=> out_valid && status == ST_ZERO)
    else $error("zero size not refused at once");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .req_type(req_type), .request_size(request_size), .out_valid(out_valid),
  .out_ready(out_ready), .granted_offset(granted_offset), .status(status)
);
